/* rtl/sbcfe_pkg.sv */
// Shared types, packet constants and helpers for the bus-servo frame encoder.
package sbcfe_pkg;

  // Number of servos addressed by a synchronous write
  localparam int SYNC_SLOTS = 6;
  localparam int SLOT_W     = (SYNC_SLOTS > 1) ? $clog2(SYNC_SLOTS) : 1;

  localparam int POS_W     = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEDIAN    = 2'd2;

  localparam logic [CFG_W-1:0] MIN_PULSE_RST = 16'd500;
  localparam logic [CFG_W-1:0] MAX_PULSE_RST = 16'd2500;
  localparam logic [CFG_W-1:0] MEDIAN_RST    = 16'd1500;
  localparam logic [POS_W-1:0] SLOT_RST      = 16'd1500;

  // Highest id accepted by the set-id command
  localparam logic [7:0] ID_MAX = 8'd250;

  // Packet bytes
  localparam logic [7:0] PKT_HDR        = 8'hFF;
  localparam logic [7:0] BCAST_ID       = 8'hFE;
  localparam logic [7:0] LEN_MOVE       = 8'h07;
  localparam logic [7:0] LEN_SHORT      = 8'h04;
  localparam logic [7:0] INSTR_WRITE    = 8'h03;
  localparam logic [7:0] INSTR_READ     = 8'h02;
  localparam logic [7:0] INSTR_SYNC     = 8'h83;
  localparam logic [7:0] ADDR_GOAL_POS  = 8'h2A;
  localparam logic [7:0] ADDR_TORQUE    = 8'h28;
  localparam logic [7:0] ADDR_ID        = 8'h05;
  localparam logic [7:0] ADDR_PRES_POS  = 8'h38;
  localparam logic [7:0] SYNC_DATA_LEN  = 8'h04;
  localparam logic [7:0] READ_LEN       = 8'h02;
  localparam logic [7:0] LEN_SYNC       = 8'(5 * SYNC_SLOTS + 4);

  // Body sizes (bytes between header and checksum)
  localparam int MOVE_BODY     = 8;
  localparam int SHORT_BODY    = 5;
  localparam int SYNC_HDR_BODY = 5;
  localparam int SLOT_BYTES    = 5;
  localparam int SYNC_BODY     = SYNC_HDR_BODY + SLOT_BYTES * SYNC_SLOTS;
  localparam int SYNC_PKT      = SYNC_BODY + 3;
  localparam int IDX_W         = $clog2(SYNC_PKT);

  typedef enum logic [2:0] {
    MODE_MOVE   = 3'd0,
    MODE_LOAD   = 3'd1,
    MODE_SYNC   = 3'd2,
    MODE_TORQUE = 3'd3,
    MODE_SET_ID = 3'd4,
    MODE_READ   = 3'd5
  } mode_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;  // input transfer this cycle
    logic step;     // produce next packet byte into the output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic needs_pkt;  // offered item produces a packet
    logic out_free;   // output register can take a byte
    logic last;       // current byte is the checksum
  } dp_status_t;

  // Out-of-range positions are replaced by the median
  function automatic logic [POS_W-1:0] clamp_pos(input logic [POS_W-1:0] p,
                                                 input logic [CFG_W-1:0] lo,
                                                 input logic [CFG_W-1:0] hi,
                                                 input logic [CFG_W-1:0] med);
    logic out_of_range;
    out_of_range = (p > hi) || (p < lo);
    return out_of_range ? med : p;
  endfunction

endpackage

/* rtl/sbcfe_ctrl.sv */
// Controller state machine: input handshake and byte sequencing.
module sbcfe_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sbcfe_pkg::dp_status_t sts,
  output sbcfe_pkg::dp_cmd_t    cmd
);
  import sbcfe_pkg::*;

  state_t state_r, state_nxt;
  logic   accept;

  assign accept = in_valid && !in_stall;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && sts.needs_pkt) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free && sts.last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall    = 1'b1;
    cmd.capture = 1'b0;
    cmd.step    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_EMIT: begin
        cmd.step = sts.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

/* rtl/sbcfe_dp.sv */
// Datapath: config registers, sync slots, byte mux, checksum and output register.
module sbcfe_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sbcfe_pkg::dp_cmd_t           cmd,
  output sbcfe_pkg::dp_status_t        sts,
  input  logic                         cfg_wr_en,
  input  logic [sbcfe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sbcfe_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic [2:0]                   in_mode,
  input  logic [7:0]                   in_servo_id,
  input  logic [15:0]                  in_position,
  input  logic [15:0]                  in_move_time,
  input  logic                         in_torque_on,
  input  logic [15:0]                  in_sync_pos_1,
  input  logic [15:0]                  in_sync_pos_2,
  input  logic [15:0]                  in_sync_pos_3,
  input  logic [15:0]                  in_sync_pos_4,
  input  logic [15:0]                  in_sync_pos_5,
  input  logic [15:0]                  in_sync_pos_6,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_tx_byte,
  output logic                         out_last_byte
);
  import sbcfe_pkg::*;

  logic [CFG_W-1:0] min_pulse_r, max_pulse_r, median_r;
  logic [POS_W-1:0] slot_pos_r [SYNC_SLOTS];
  logic [POS_W-1:0] sync_in [6];

  mode_t            mode_in;
  mode_t            mode_r;
  logic [7:0]       id_r;
  logic [POS_W-1:0] pos_r;
  logic [15:0]      time_r;
  logic             torque_r;

  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] body_idx;
  logic [IDX_W-1:0] last_idx;
  logic [2:0]       sub_r;
  logic [SLOT_W-1:0] slot_r;
  logic [7:0]       sum_r;
  logic [7:0]       body_byte;
  logic [7:0]       slot_byte;
  logic [7:0]       tx_nxt;
  logic             is_last;
  logic             in_body;
  logic             in_slots;
  logic             needs_pkt;
  logic [POS_W-1:0] cur_slot_pos;

  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_last_r;

  assign mode_in = mode_t'(in_mode);
  assign sync_in[0] = in_sync_pos_1;
  assign sync_in[1] = in_sync_pos_2;
  assign sync_in[2] = in_sync_pos_3;
  assign sync_in[3] = in_sync_pos_4;
  assign sync_in[4] = in_sync_pos_5;
  assign sync_in[5] = in_sync_pos_6;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_pulse_r <= MIN_PULSE_RST;
      max_pulse_r <= MAX_PULSE_RST;
      median_r    <= MEDIAN_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_MIN_PULSE: min_pulse_r <= cfg_wdata;
        CFG_MAX_PULSE: max_pulse_r <= cfg_wdata;
        CFG_MEDIAN:    median_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sync slot positions, loaded clamped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SYNC_SLOTS; i++) slot_pos_r[i] <= SLOT_RST;
    end else if (cmd.capture && mode_in == MODE_LOAD) begin
      for (int i = 0; i < SYNC_SLOTS; i++) begin
        slot_pos_r[i] <= clamp_pos(sync_in[i], min_pulse_r, max_pulse_r, median_r);
      end
    end
  end

  // Command fields latched on input transfer
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r   <= mode_in;
      id_r     <= in_servo_id;
      pos_r    <= clamp_pos(in_position, min_pulse_r, max_pulse_r, median_r);
      time_r   <= in_move_time;
      torque_r <= in_torque_on;
    end
  end

  // Whether the offered item produces a packet
  always_comb begin
    case (mode_in)
      MODE_MOVE, MODE_SYNC, MODE_TORQUE, MODE_READ: needs_pkt = 1'b1;
      MODE_SET_ID: needs_pkt = (in_servo_id != 8'd0) && (in_servo_id <= ID_MAX);
      default: needs_pkt = 1'b0;
    endcase
  end

  // Index of the checksum byte per packet type
  always_comb begin
    case (mode_r)
      MODE_MOVE: last_idx = IDX_W'(MOVE_BODY + 2);
      MODE_SYNC: last_idx = IDX_W'(SYNC_BODY + 2);
      default:   last_idx = IDX_W'(SHORT_BODY + 2);
    endcase
  end

  // Slot records only inside the body; header bytes would wrap body_idx
  assign body_idx     = idx_r - IDX_W'(2);
  assign is_last      = (idx_r == last_idx);
  assign in_body      = (idx_r >= IDX_W'(2)) && !is_last;
  assign in_slots     = in_body && (mode_r == MODE_SYNC) &&
                        (body_idx >= IDX_W'(SYNC_HDR_BODY));
  assign cur_slot_pos = slot_pos_r[slot_r];

  // Byte within one servo's record of a sync write
  always_comb begin
    case (sub_r)
      3'd0:    slot_byte = 8'(slot_r) + 8'd1;
      3'd1:    slot_byte = cur_slot_pos[15:8];
      3'd2:    slot_byte = cur_slot_pos[7:0];
      3'd3:    slot_byte = time_r[15:8];
      default: slot_byte = time_r[7:0];
    endcase
  end

  // Body byte mux
  always_comb begin
    body_byte = 8'd0;
    case (mode_r)
      MODE_MOVE: begin
        case (body_idx)
          IDX_W'(0): body_byte = id_r;
          IDX_W'(1): body_byte = LEN_MOVE;
          IDX_W'(2): body_byte = INSTR_WRITE;
          IDX_W'(3): body_byte = ADDR_GOAL_POS;
          IDX_W'(4): body_byte = pos_r[15:8];
          IDX_W'(5): body_byte = pos_r[7:0];
          IDX_W'(6): body_byte = time_r[15:8];
          default:   body_byte = time_r[7:0];
        endcase
      end
      MODE_SYNC: begin
        if (in_slots) begin
          body_byte = slot_byte;
        end else begin
          case (body_idx)
            IDX_W'(0): body_byte = BCAST_ID;
            IDX_W'(1): body_byte = LEN_SYNC;
            IDX_W'(2): body_byte = INSTR_SYNC;
            IDX_W'(3): body_byte = ADDR_GOAL_POS;
            default:   body_byte = SYNC_DATA_LEN;
          endcase
        end
      end
      MODE_TORQUE: begin
        case (body_idx)
          IDX_W'(0): body_byte = BCAST_ID;
          IDX_W'(1): body_byte = LEN_SHORT;
          IDX_W'(2): body_byte = INSTR_WRITE;
          IDX_W'(3): body_byte = ADDR_TORQUE;
          default:   body_byte = {7'd0, torque_r};
        endcase
      end
      MODE_SET_ID: begin
        case (body_idx)
          IDX_W'(0): body_byte = BCAST_ID;
          IDX_W'(1): body_byte = LEN_SHORT;
          IDX_W'(2): body_byte = INSTR_WRITE;
          IDX_W'(3): body_byte = ADDR_ID;
          default:   body_byte = id_r;
        endcase
      end
      MODE_READ: begin
        case (body_idx)
          IDX_W'(0): body_byte = id_r;
          IDX_W'(1): body_byte = LEN_SHORT;
          IDX_W'(2): body_byte = INSTR_READ;
          IDX_W'(3): body_byte = ADDR_PRES_POS;
          default:   body_byte = READ_LEN;
        endcase
      end
      default: body_byte = 8'd0;
    endcase
  end

  // Header, body or checksum
  always_comb begin
    if (idx_r < IDX_W'(2)) begin
      tx_nxt = PKT_HDR;
    end else if (is_last) begin
      tx_nxt = ~sum_r;
    end else begin
      tx_nxt = body_byte;
    end
  end

  // Byte counters and running sum
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx_r  <= '0;
      sub_r  <= 3'd0;
      slot_r <= '0;
      sum_r  <= 8'd0;
    end else if (cmd.step) begin
      idx_r <= idx_r + IDX_W'(1);
      if (in_body) sum_r <= sum_r + body_byte;
      if (in_slots && !is_last) begin
        if (sub_r == 3'(SLOT_BYTES - 1)) begin
          sub_r <= 3'd0;
          if (slot_r != SLOT_W'(SYNC_SLOTS - 1)) slot_r <= slot_r + SLOT_W'(1);
        end else begin
          sub_r <= sub_r + 3'd1;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.step) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      out_byte_r <= tx_nxt;
      out_last_r <= is_last;
    end
  end

  assign sts.needs_pkt = needs_pkt;
  assign sts.out_free  = !out_valid_r || !out_stall;
  assign sts.last      = is_last;

  assign out_valid     = out_valid_r;
  assign out_tx_byte   = out_byte_r;
  assign out_last_byte = out_last_r;

endmodule

/* rtl/servo_bus_command_frame_encoder.sv */
// Bus-servo command frame encoder: top level.
// Throughput: one byte per cycle from the byte sequencer when the output is not stalled; the
//   input stays stalled while an item's packet is emitted, until its checksum byte has been
//   stepped into the output register, and an item that emits nothing never stalls the input.
// Reset: synchronous, active low; restores the config registers and sync slots.
module servo_bus_command_frame_encoder (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [sbcfe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sbcfe_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [2:0]                       in_mode,
  input  logic [7:0]                       in_servo_id,
  input  logic [15:0]                      in_position,
  input  logic [15:0]                      in_move_time,
  input  logic                             in_torque_on,
  input  logic [15:0]                      in_sync_pos_1,
  input  logic [15:0]                      in_sync_pos_2,
  input  logic [15:0]                      in_sync_pos_3,
  input  logic [15:0]                      in_sync_pos_4,
  input  logic [15:0]                      in_sync_pos_5,
  input  logic [15:0]                      in_sync_pos_6,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       out_tx_byte,
  output logic                             out_last_byte
);
  import sbcfe_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t sts;

  sbcfe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sbcfe_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_mode       (in_mode),
    .in_servo_id   (in_servo_id),
    .in_position   (in_position),
    .in_move_time  (in_move_time),
    .in_torque_on  (in_torque_on),
    .in_sync_pos_1 (in_sync_pos_1),
    .in_sync_pos_2 (in_sync_pos_2),
    .in_sync_pos_3 (in_sync_pos_3),
    .in_sync_pos_4 (in_sync_pos_4),
    .in_sync_pos_5 (in_sync_pos_5),
    .in_sync_pos_6 (in_sync_pos_6),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_tx_byte   (out_tx_byte),
    .out_last_byte (out_last_byte)
  );

endmodule

/* rtl/sbcfe_chk.sv */
// Port-level checker for the frame encoder, bound to the top level.
module sbcfe_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_tx_byte,
  input logic       out_last_byte
);
  import sbcfe_pkg::*;

  // Bytes transferred so far in the current packet, saturating at two
  logic [1:0] pkt_cnt_r;
  logic       out_xfer;

  assign out_xfer = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkt_cnt_r <= 2'd0;
    end else if (out_xfer) begin
      if (out_last_byte) begin
        pkt_cnt_r <= 2'd0;
      end else if (pkt_cnt_r != 2'd2) begin
        pkt_cnt_r <= pkt_cnt_r + 2'd1;
      end
    end
  end

  // A stalled byte stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_tx_byte) && $stable(out_last_byte))
    else $error("output byte changed while stalled");

  // Nothing is offered right after reset
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // Every packet opens with two header bytes
  a_hdr_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && pkt_cnt_r == 2'd0 |-> out_tx_byte == PKT_HDR && !out_last_byte)
    else $error("packet does not open with header byte");

  a_hdr_second: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && pkt_cnt_r == 2'd1 |-> out_tx_byte == PKT_HDR && !out_last_byte)
    else $error("second header byte missing");

endmodule

bind servo_bus_command_frame_encoder sbcfe_chk u_sbcfe_chk (.*);

/* tb/sv/servo_bus_command_frame_encoder_tb.sv */
// Self-checking testbench for the bus-servo command frame encoder.
`timescale 1ns / 100ps

module servo_bus_command_frame_encoder_tb;
  import sbcfe_pkg::*;

  // Mode codes outside the defined command set
  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  // Register index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  localparam int PHASE_ITEMS = 95;

  // One command request
  typedef struct {
    logic [2:0]  mode;
    logic [7:0]  servo_id;
    logic [15:0] position;
    logic [15:0] move_time;
    logic        torque_on;
    logic [15:0] sync_pos [6];
  } servo_cmd_t;

  // One packet byte as seen on the result channel
  typedef struct packed {
    logic [7:0] tx;
    logic       last;
  } frame_byte_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [2:0]           in_mode = '0;
  logic [7:0]           in_servo_id = '0;
  logic [15:0]          in_position = '0;
  logic [15:0]          in_move_time = '0;
  logic                 in_torque_on = 1'b0;
  logic [15:0]          in_sync_pos_1 = '0;
  logic [15:0]          in_sync_pos_2 = '0;
  logic [15:0]          in_sync_pos_3 = '0;
  logic [15:0]          in_sync_pos_4 = '0;
  logic [15:0]          in_sync_pos_5 = '0;
  logic [15:0]          in_sync_pos_6 = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [7:0]           out_tx_byte;
  logic                 out_last_byte;

  // Predictor copy of the registers and the sync slots
  logic [15:0] lim_lo  = MIN_PULSE_RST;
  logic [15:0] lim_hi  = MAX_PULSE_RST;
  logic [15:0] lim_med = MEDIAN_RST;
  logic [15:0] slot_pos [6] = '{default: SLOT_RST};

  frame_byte_t frame_bytes[$];
  frame_byte_t want_byte;
  int          mismatch_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          send_quiet = 0;
  int          recv_quiet = 0;

  servo_bus_command_frame_encoder uut (.*);

  always #5 clk = ~clk;

  // Position gate: out-of-range requests fall back to the median
  function automatic logic [15:0] limit_position(input logic [15:0] p);
    if (p < lim_lo || p > lim_hi) return lim_med;
    return p;
  endfunction

  // Expected packet bytes for one accepted request; also updates slot state
  function automatic void predict_frame(input servo_cmd_t c);
    logic [7:0]  body[$];
    logic [15:0] pos;
    logic [7:0]  sum;
    int          k;
    sum = 8'd0;
    case (c.mode)
      MODE_MOVE: begin
        pos  = limit_position(c.position);
        body = '{c.servo_id, LEN_MOVE, INSTR_WRITE, ADDR_GOAL_POS, pos[15:8], pos[7:0],
                 c.move_time[15:8], c.move_time[7:0]};
      end
      MODE_LOAD: begin
        for (k = 0; k < SYNC_SLOTS; k++) slot_pos[k] = limit_position(c.sync_pos[k]);
      end
      MODE_SYNC: begin
        body = '{BCAST_ID, LEN_SYNC, INSTR_SYNC, ADDR_GOAL_POS, SYNC_DATA_LEN};
        for (k = 0; k < SYNC_SLOTS; k++) begin
          body.push_back(8'(k + 1));
          body.push_back(slot_pos[k][15:8]);
          body.push_back(slot_pos[k][7:0]);
          body.push_back(c.move_time[15:8]);
          body.push_back(c.move_time[7:0]);
        end
      end
      MODE_TORQUE: body = '{BCAST_ID, LEN_SHORT, INSTR_WRITE, ADDR_TORQUE, {7'd0, c.torque_on}};
      MODE_SET_ID: begin
        if (c.servo_id >= 8'd1 && c.servo_id <= ID_MAX)
          body = '{BCAST_ID, LEN_SHORT, INSTR_WRITE, ADDR_ID, c.servo_id};
      end
      MODE_READ: body = '{c.servo_id, LEN_SHORT, INSTR_READ, ADDR_PRES_POS, READ_LEN};
      default: ;
    endcase
    if (body.size() == 0) return;
    frame_bytes.push_back('{PKT_HDR, 1'b0});
    frame_bytes.push_back('{PKT_HDR, 1'b0});
    foreach (body[j]) begin
      sum = sum + body[j];
      frame_bytes.push_back('{body[j], 1'b0});
    end
    frame_bytes.push_back('{~sum, 1'b1});
  endfunction

  // Receiver: random stall with occasional stall-free runs
  always @(posedge clk) begin
    if (recv_quiet > 0) begin
      recv_quiet <= recv_quiet - 1;
      out_stall  <= 1'b0;
    end else if ($urandom_range(99) < 2) begin
      recv_quiet <= 24;
      out_stall  <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Compare every result transfer against the oldest expected byte
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (frame_bytes.size() == 0) begin
        $error("unexpected byte: tx_byte %0h last_byte %0b", out_tx_byte, out_last_byte);
        mismatch_count++;
      end else begin
        want_byte = frame_bytes.pop_front();
        if (out_tx_byte !== want_byte.tx) begin
          $error("tx_byte: expected %0h, actual %0h", want_byte.tx, out_tx_byte);
          mismatch_count++;
        end
        if (out_last_byte !== want_byte.last) begin
          $error("last_byte: expected %0b, actual %0b", want_byte.last, out_last_byte);
          mismatch_count++;
        end
      end
    end
  end

  // Offer one request, hold it until the transfer, then predict its packet.
  // Valid stays high afterwards so back-to-back requests need no gap.
  task automatic send_command(input servo_cmd_t c);
    int gap;
    gap = 0;
    if (send_quiet > 0) begin
      send_quiet--;
    end else if ($urandom_range(99) < 2) begin
      send_quiet = 24;
    end else begin
      while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= c.mode;
    in_servo_id   <= c.servo_id;
    in_position   <= c.position;
    in_move_time  <= c.move_time;
    in_torque_on  <= c.torque_on;
    in_sync_pos_1 <= c.sync_pos[0];
    in_sync_pos_2 <= c.sync_pos[1];
    in_sync_pos_3 <= c.sync_pos[2];
    in_sync_pos_4 <= c.sync_pos[3];
    in_sync_pos_5 <= c.sync_pos[4];
    in_sync_pos_6 <= c.sync_pos[5];
    do @(posedge clk); while (in_stall);
    predict_frame(c);
  endtask

  task automatic send_op(input logic [2:0] mode, input logic [7:0] id,
                         input logic [15:0] pos, input logic [15:0] mtime,
                         input logic torque);
    servo_cmd_t c;
    c.mode      = mode;
    c.servo_id  = id;
    c.position  = pos;
    c.move_time = mtime;
    c.torque_on = torque;
    foreach (c.sync_pos[k]) c.sync_pos[k] = pos;
    send_command(c);
  endtask

  // Drop valid and hold off until every expected byte has arrived
  task automatic wait_until_flushed();
    in_valid <= 1'b0;
    while (frame_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write; the caller lowers the write enable after the last one
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_MIN_PULSE: lim_lo  = val;
      CFG_MAX_PULSE: lim_hi  = val;
      CFG_MEDIAN:    lim_med = val;
      default: ;
    endcase
  endtask

  task automatic set_limits(input logic [15:0] lo, input logic [15:0] hi,
                            input logic [15:0] med);
    wait_until_flushed();
    write_register(CFG_MIN_PULSE, lo);
    write_register(CFG_MAX_PULSE, hi);
    write_register(CFG_MEDIAN, med);
    cfg_wr_en <= 1'b0;
  endtask

  // Positions at and just outside the current window edges, inside the window, or anywhere
  function automatic logic [15:0] pick_position();
    case ($urandom_range(6))
      0: return lim_lo;
      1: return lim_hi;
      2: return lim_lo - 16'd1;
      3: return lim_hi + 16'd1;
      4: return (lim_lo <= lim_hi) ? 16'($urandom_range(lim_hi, lim_lo)) : 16'($urandom);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic servo_cmd_t random_command();
    servo_cmd_t c;
    int r;
    r = $urandom_range(99);
    if (r < 28)      c.mode = MODE_MOVE;
    else if (r < 44) c.mode = MODE_LOAD;
    else if (r < 58) c.mode = MODE_SYNC;
    else if (r < 68) c.mode = MODE_TORQUE;
    else if (r < 81) c.mode = MODE_SET_ID;
    else if (r < 95) c.mode = MODE_READ;
    else if (r < 97) c.mode = MODE_SPARE_LO;
    else             c.mode = MODE_SPARE_HI;
    c.servo_id = 8'($urandom);
    if (c.mode == MODE_SET_ID && $urandom_range(3) != 0)
      c.servo_id = 8'($urandom_range(ID_MAX, 1));
    c.position  = pick_position();
    c.move_time = 16'($urandom);
    c.torque_on = 1'($urandom);
    foreach (c.sync_pos[k]) c.sync_pos[k] = pick_position();
    return c;
  endfunction

  task automatic pick_limits();
    logic [15:0] a;
    logic [15:0] b;
    a = 16'($urandom);
    b = 16'($urandom);
    case ($urandom_range(4))
      0: set_limits(16'd0, 16'hFFFF, 16'($urandom));
      1: set_limits((a > b) ? a : b, (a > b) ? b : a, 16'($urandom));
      2: set_limits(MIN_PULSE_RST, MAX_PULSE_RST, MEDIAN_RST);
      default: set_limits((a < b) ? a : b, (a < b) ? b : a, 16'($urandom));
    endcase
  endtask

  // Defaults after reset: untouched slots and the default position window
  task automatic test_reset_defaults();
    send_op(MODE_SYNC, 8'd0, 16'd0, 16'h1234, 1'b0);
    send_op(MODE_MOVE, 8'd0, 16'd0, 16'd0, 1'b0);
    send_op(MODE_MOVE, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_op(MODE_MOVE, 8'd1, MIN_PULSE_RST - 16'd1, 16'd100, 1'b0);
    send_op(MODE_MOVE, 8'd2, MIN_PULSE_RST, 16'd100, 1'b0);
    send_op(MODE_MOVE, 8'd3, MAX_PULSE_RST, 16'd100, 1'b0);
    send_op(MODE_MOVE, 8'd4, MAX_PULSE_RST + 16'd1, 16'd100, 1'b0);
  endtask

  // Fixed-length frames, set-id range edges and the unused modes
  task automatic test_short_frames();
    send_op(MODE_TORQUE, 8'd0, 16'd0, 16'd0, 1'b1);
    send_op(MODE_TORQUE, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_op(MODE_READ, 8'd0, 16'd0, 16'd0, 1'b0);
    send_op(MODE_READ, 8'hFF, 16'd0, 16'd0, 1'b1);
    send_op(MODE_SET_ID, 8'd0, 16'd0, 16'd0, 1'b0);
    send_op(MODE_SET_ID, 8'd1, 16'd0, 16'd0, 1'b0);
    send_op(MODE_SET_ID, ID_MAX, 16'd0, 16'd0, 1'b0);
    send_op(MODE_SET_ID, ID_MAX + 8'd1, 16'd0, 16'd0, 1'b0);
    send_op(MODE_SET_ID, 8'hFF, 16'd0, 16'd0, 1'b0);
    send_op(MODE_SPARE_LO, 8'd7, 16'd700, 16'd7, 1'b1);
    send_op(MODE_SPARE_HI, 8'd9, 16'd900, 16'd9, 1'b1);
  endtask

  // Slot load with a mix of in-range and rejected positions, then broadcast
  task automatic test_slot_load();
    servo_cmd_t c;
    c.mode        = MODE_LOAD;
    c.servo_id    = 8'd0;
    c.position    = 16'd0;
    c.move_time   = 16'd0;
    c.torque_on   = 1'b0;
    c.sync_pos[0] = MIN_PULSE_RST;
    c.sync_pos[1] = MAX_PULSE_RST;
    c.sync_pos[2] = 16'd0;
    c.sync_pos[3] = 16'hFFFF;
    c.sync_pos[4] = 16'd1234;
    c.sync_pos[5] = MAX_PULSE_RST + 16'd1;
    send_command(c);
    send_op(MODE_SYNC, 8'd0, 16'd0, 16'hA5C3, 1'b0);
  endtask

  // Register extremes, min above max, and a write to the spare index
  task automatic test_limit_registers();
    set_limits(16'd0, 16'hFFFF, 16'd0);
    send_op(MODE_MOVE, 8'd10, 16'd0, 16'd1, 1'b0);
    send_op(MODE_MOVE, 8'd11, 16'hFFFF, 16'd1, 1'b0);
    set_limits(16'd3000, 16'd1000, 16'hFFFF);
    send_op(MODE_MOVE, 8'd12, 16'd2000, 16'd2, 1'b0);
    send_op(MODE_LOAD, 8'd0, 16'd2000, 16'd0, 1'b0);
    send_op(MODE_SYNC, 8'd0, 16'd0, 16'd3, 1'b0);
    set_limits(16'hFFFF, 16'hFFFF, 16'd0);
    send_op(MODE_MOVE, 8'd13, 16'hFFFF, 16'd4, 1'b0);
    send_op(MODE_MOVE, 8'd14, 16'hFFFE, 16'd4, 1'b0);
    wait_until_flushed();
    write_register(CFG_SPARE, 16'h5A5A);
    cfg_wr_en <= 1'b0;
    send_op(MODE_MOVE, 8'd15, 16'd100, 16'd5, 1'b0);
    set_limits(MIN_PULSE_RST, MAX_PULSE_RST, MEDIAN_RST);
  endtask

  // Random traffic under one handshake pressure setting
  task automatic test_random_traffic(input int idle_pct, input int stall_pct);
    servo_cmd_t c;
    int counted;
    logic mid_done;
    counted  = 0;
    mid_done = 1'b0;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    pick_limits();
    while (counted < PHASE_ITEMS) begin
      if (!mid_done && counted >= PHASE_ITEMS / 2) begin
        pick_limits();
        mid_done = 1'b1;
      end
      c = random_command();
      send_command(c);
      counted++;
      // load usually followed by the broadcast that uses it
      if (c.mode == MODE_LOAD && $urandom_range(9) < 7) begin
        c.mode      = MODE_SYNC;
        c.move_time = 16'($urandom);
        send_command(c);
        counted++;
      end
      if ($urandom_range(49) == 0) wait_until_flushed();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_short_frames();
    test_slot_load();
    test_limit_registers();
    test_random_traffic(0, 0);
    test_random_traffic(72, 0);
    test_random_traffic(0, 72);
    test_random_traffic(14, 14);
    wait_until_flushed();
    repeat (12) @(posedge clk);
    if (frame_bytes.size() != 0) begin
      $error("%0d expected bytes never arrived", frame_bytes.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("servo_bus_command_frame_encoder test passed");
    end else begin
      $display("servo_bus_command_frame_encoder test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("servo_bus_command_frame_encoder test failed");
    $finish;
  end

endmodule
